FILE: sv/pbd_pkg.sv
package pbd_pkg;

  // Fixed field widths of the two channels
  localparam int FIELD_BITS = 8;
  localparam int DEG_W      = 3;
  localparam int ACC_W      = 64;
  // Widest sample the front can extract from a field
  localparam int RAW_BITS   = 16;

  localparam logic [DEG_W-1:0] DEG_RESET = 3'd2;

  localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] S64_ONE = 64'sd1;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] u_value;
    logic signed [FIELD_BITS-1:0] v_value;
    logic                         last;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] divergence;
    logic                    saturated;
  } out_word_t;

endpackage

FILE: sv/pbd_fifo.sv
module pbd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and word count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: sv/pbd_front.sv
module pbd_front #(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_DEGREE  = 7,
  parameter int Q_W         = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [pbd_pkg::DEG_W-1:0] cfg_wdata,
  input  logic                    in_push,
  output logic                    in_full,
  input  pbd_pkg::in_word_t       in_word,
  output logic                    q_push,
  input  logic                    q_full,
  output logic [Q_W-1:0]          q_word
);

  import pbd_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int LIN_W = SAMPLE_BITS + 4;
  localparam logic [DEG_W:0] MAXD = (DEG_W+1)'(MAX_DEGREE);

  typedef struct packed {
    logic signed [SB-1:0]    u;
    logic signed [SB-1:0]    v;
    logic signed [LIN_W-1:0] lin0;
    logic [DEG_W-1:0]        deg;
    logic                    add_lin;
    logic                    last;
  } q_word_t;

  logic [DEG_W-1:0]     deg_r;
  logic [DEG_W-1:0]     deg_eff;
  logic [RAW_BITS-1:0]  raw_u, raw_v;
  logic signed [SB-1:0] samp_u, samp_v;
  logic signed [SB:0]   diff;
  logic signed [SB+4:0] diff_x, deg_x, prod;
  q_word_t              ent;

  // Hold the degree register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= DEG_RESET;
    end else if (cfg_we) begin
      deg_r <= cfg_wdata;
    end
  end

  // Clamp the degree into the supported range
  always_comb begin
    if (deg_r == '0) begin
      deg_eff = DEG_W'(1);
    end else if ({1'b0, deg_r} > MAXD) begin
      deg_eff = MAXD[DEG_W-1:0];
    end else begin
      deg_eff = deg_r;
    end
  end

  // Extract samples from the low bits of each field
  assign raw_u  = {{(RAW_BITS-FIELD_BITS){1'b0}}, in_word.u_value};
  assign raw_v  = {{(RAW_BITS-FIELD_BITS){1'b0}}, in_word.v_value};
  assign samp_u = raw_u[SB-1:0];
  assign samp_v = raw_v[SB-1:0];

  // Form d*(u-v); it never exceeds LIN_W signed bits
  assign diff   = {samp_u[SB-1], samp_u} - {samp_v[SB-1], samp_v};
  assign diff_x = {{4{diff[SB]}}, diff};
  assign deg_x  = {{(SB+5-DEG_W){1'b0}}, deg_eff};
  assign prod   = diff_x * deg_x;

  // Classify: odd degree with v at or below zero adds the linear term
  always_comb begin
    ent.u       = samp_u;
    ent.v       = samp_v;
    ent.lin0    = prod[LIN_W-1:0];
    ent.deg     = deg_eff;
    ent.add_lin = deg_eff[0] && (samp_v[SB-1] || (samp_v == '0));
    ent.last    = in_word.last;
  end

  assign q_word  = ent;
  assign q_push  = in_push;
  assign in_full = q_full;

endmodule

FILE: sv/pbd_back.sv
module pbd_back #(
  parameter int SAMPLE_BITS = 8,
  parameter int Q_W         = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [Q_W-1:0]     q_word,
  output logic               r_push,
  input  logic               r_full,
  output pbd_pkg::out_word_t r_word
);

  import pbd_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int LIN_W = SAMPLE_BITS + 4;
  localparam int P_W   = ACC_W + LIN_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PU     = 4'd1;
  localparam logic [3:0] ST_PV     = 4'd2;
  localparam logic [3:0] ST_LIN    = 4'd3;
  localparam logic [3:0] ST_NEGPV  = 4'd4;
  localparam logic [3:0] ST_ADD1   = 4'd5;
  localparam logic [3:0] ST_NEGLIN = 4'd6;
  localparam logic [3:0] ST_ADD2   = 4'd7;
  localparam logic [3:0] ST_ACC    = 4'd8;

  typedef struct packed {
    logic signed [SB-1:0]    u;
    logic signed [SB-1:0]    v;
    logic signed [LIN_W-1:0] lin0;
    logic [DEG_W-1:0]        deg;
    logic                    add_lin;
    logic                    last;
  } q_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    clip;
  } sat_res_t;

  // Saturating multiply of a 64-bit value by a narrow signed operand
  function automatic sat_res_t sat_mul(input logic signed [ACC_W-1:0] a,
                                       input logic signed [LIN_W-1:0] b);
    logic [ACC_W-1:0] ua;
    logic [LIN_W-1:0] ub;
    logic [P_W-1:0]   p;
    logic [P_W-1:0]   pmax;
    logic [P_W-1:0]   plim;
    logic             neg;
    sat_res_t         r;
    ua   = a[ACC_W-1] ? (~a + ACC_W'(1)) : a;
    ub   = b[LIN_W-1] ? (~b + LIN_W'(1)) : b;
    p    = {{LIN_W{1'b0}}, ua} * {{ACC_W{1'b0}}, ub};
    pmax = {{LIN_W{1'b0}}, 1'b0, {(ACC_W-1){1'b1}}};
    plim = {{LIN_W{1'b0}}, 1'b1, {(ACC_W-1){1'b0}}};
    neg  = a[ACC_W-1] ^ b[LIN_W-1];
    r.clip = 1'b0;
    if (!neg) begin
      if (p > pmax) begin
        r.val  = S64_MAX;
        r.clip = 1'b1;
      end else begin
        r.val = p[ACC_W-1:0];
      end
    end else begin
      if (p > plim) begin
        r.val  = S64_MIN;
        r.clip = 1'b1;
      end else begin
        r.val = ~p[ACC_W-1:0] + ACC_W'(1);
      end
    end
    return r;
  endfunction

  // Saturating add
  function automatic sat_res_t sat_add(input logic signed [ACC_W-1:0] a,
                                       input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    sat_res_t       r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.val  = s[ACC_W] ? S64_MIN : S64_MAX;
      r.clip = 1'b1;
    end else begin
      r.val  = s[ACC_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Saturating negate
  function automatic sat_res_t sat_neg(input logic signed [ACC_W-1:0] a);
    sat_res_t r;
    if (a == S64_MIN) begin
      r.val  = S64_MAX;
      r.clip = 1'b1;
    end else begin
      r.val  = ~a + ACC_W'(1);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [DEG_W-1:0]        cnt_r, cnt_nxt;
  q_word_t                 ent_r, ent_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] pu_r, pu_nxt;
  logic signed [ACC_W-1:0] pvd1_r, pvd1_nxt;
  logic signed [ACC_W-1:0] lin_r, lin_nxt;
  logic signed [ACC_W-1:0] t_r, t_nxt;
  logic signed [ACC_W-1:0] sum_r, sum_nxt;
  logic                    clip_r, clip_nxt;
  logic                    seen_r, seen_nxt;

  logic signed [ACC_W-1:0] mul_a, neg_a, add_a, add_b;
  logic signed [LIN_W-1:0] mul_b;
  sat_res_t                mres, nres, ares;
  logic                    last_mul;
  logic                    seen_new;

  // Select operands of the shared units
  always_comb begin
    mul_a = (state_r == ST_LIN) ? pvd1_r : acc_r;
    priority if (state_r == ST_PU) begin
      mul_b = {{(LIN_W-SB){ent_r.u[SB-1]}}, ent_r.u};
    end else if (state_r == ST_PV) begin
      mul_b = {{(LIN_W-SB){ent_r.v[SB-1]}}, ent_r.v};
    end else begin
      mul_b = ent_r.lin0;
    end
    neg_a = (state_r == ST_NEGPV) ? t_r : lin_r;
    priority if (state_r == ST_ADD1) begin
      add_a = pu_r;
      add_b = t_r;
    end else if (state_r == ST_ADD2) begin
      add_a = t_r;
      add_b = lin_r;
    end else begin
      add_a = sum_r;
      add_b = t_r;
    end
  end

  assign mres     = sat_mul(mul_a, mul_b);
  assign nres     = sat_neg(neg_a);
  assign ares     = sat_add(add_a, add_b);
  assign last_mul = (cnt_r == (ent_r.deg - DEG_W'(1)));
  assign seen_new = seen_r | clip_r | ares.clip;

  assign r_word.divergence = ares.val;
  assign r_word.saturated  = seen_new;

  // Sequence one word through powers, linear term and accumulation
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ent_nxt   = ent_r;
    acc_nxt   = acc_r;
    pu_nxt    = pu_r;
    pvd1_nxt  = pvd1_r;
    lin_nxt   = lin_r;
    t_nxt     = t_r;
    sum_nxt   = sum_r;
    clip_nxt  = clip_r;
    seen_nxt  = seen_r;
    q_pop     = 1'b0;
    r_push    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_word;
          acc_nxt   = S64_ONE;
          cnt_nxt   = '0;
          clip_nxt  = 1'b0;
          state_nxt = ST_PU;
        end
      end
      ST_PU: begin
        clip_nxt = clip_r | mres.clip;
        if (last_mul) begin
          pu_nxt    = mres.val;
          acc_nxt   = S64_ONE;
          cnt_nxt   = '0;
          state_nxt = ST_PV;
        end else begin
          acc_nxt = mres.val;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PV: begin
        clip_nxt = clip_r | mres.clip;
        if (last_mul) begin
          // acc holds v^(d-1) before the final multiply
          pvd1_nxt  = acc_r;
          t_nxt     = mres.val;
          state_nxt = ST_LIN;
        end else begin
          acc_nxt = mres.val;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LIN: begin
        lin_nxt   = mres.val;
        clip_nxt  = clip_r | mres.clip;
        state_nxt = ST_NEGPV;
      end
      ST_NEGPV: begin
        t_nxt     = nres.val;
        clip_nxt  = clip_r | nres.clip;
        state_nxt = ST_ADD1;
      end
      ST_ADD1: begin
        t_nxt     = ares.val;
        clip_nxt  = clip_r | ares.clip;
        state_nxt = ST_NEGLIN;
      end
      ST_NEGLIN: begin
        if (!ent_r.add_lin) begin
          lin_nxt  = nres.val;
          clip_nxt = clip_r | nres.clip;
        end
        state_nxt = ST_ADD2;
      end
      ST_ADD2: begin
        t_nxt     = ares.val;
        clip_nxt  = clip_r | ares.clip;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (!ent_r.last) begin
          sum_nxt   = ares.val;
          seen_nxt  = seen_new;
          state_nxt = ST_IDLE;
        end else if (!r_full) begin
          r_push    = 1'b1;
          sum_nxt   = '0;
          seen_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Hold working values
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ent_r  <= ent_nxt;
    acc_r  <= acc_nxt;
    pu_r   <= pu_nxt;
    pvd1_r <= pvd1_nxt;
    lin_r  <= lin_nxt;
    t_r    <= t_nxt;
    clip_r <= clip_nxt;
  end

endmodule

FILE: sv/polynomial_bregman_divergence_unit.sv
// The back end finishes one word before it pops the next; d is the clamped degree.
// Its shared saturating multiplier forms u^d, v^d and the linear term one product
// per cycle. A two-word queue sits between front and back, another holds results.
// Reset (synchronous, rst_n low) empties both queues, clears the running sum
// and clip flag, and sets the degree to 2.
module polynomial_bregman_divergence_unit #(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_DEGREE  = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pbd_pkg::DEG_W-1:0] cfg_wdata,
  input  logic                      in_push,
  output logic                      in_full,
  input  pbd_pkg::in_word_t         in_word,
  output logic                      out_empty,
  input  logic                      out_pop,
  output pbd_pkg::out_word_t        out_word
);

  import pbd_pkg::*;

  localparam int LIN_W = SAMPLE_BITS + 4;
  localparam int Q_W   = 2 * SAMPLE_BITS + LIN_W + DEG_W + 2;
  localparam int R_W   = $bits(out_word_t);

  logic           fq_push, fq_full, fq_pop, fq_empty;
  logic [Q_W-1:0] fq_wdata, fq_rdata;
  logic           rq_push, rq_full;
  out_word_t      rq_wdata;
  logic [R_W-1:0] rq_rdata;

  pbd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_DEGREE  (MAX_DEGREE),
    .Q_W         (Q_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .q_push    (fq_push),
    .q_full    (fq_full),
    .q_word    (fq_wdata)
  );

  pbd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_wdata),
    .pop     (fq_pop),
    .empty   (fq_empty),
    .rd_data (fq_rdata)
  );

  pbd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .Q_W         (Q_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fq_empty),
    .q_pop   (fq_pop),
    .q_word  (fq_rdata),
    .r_push  (rq_push),
    .r_full  (rq_full),
    .r_word  (rq_wdata)
  );

  pbd_fifo #(
    .WIDTH (R_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .full    (rq_full),
    .wr_data (rq_wdata),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (rq_rdata)
  );

  assign out_word = rq_rdata;

endmodule

FILE: sv/pbd_checker.sv
module pbd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_pop,
  input logic               out_empty,
  input pbd_pkg::out_word_t out_word
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_word))
    else $error("waiting result changed before pop");

  // Push while full, result unpopped: input full or result waits
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !out_empty && !out_pop && in_push |=> in_full || !out_empty)
    else $error("result dropped while input stalled");

endmodule

bind polynomial_bregman_divergence_unit pbd_checker u_pbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_word  (out_word)
);

FILE: tb/tb_polynomial_bregman_divergence_unit.sv
module tb_polynomial_bregman_divergence_unit;
  import pbd_pkg::*;

  typedef logic signed [ACC_W-1:0] s64_t;
  typedef logic signed [ACC_W:0]   s65_t;
  typedef logic signed [127:0]     s128_t;
  typedef logic signed [FIELD_BITS-1:0] sample_t;

  localparam int MAX_DEG       = 7;
  localparam int SETTLE_CYCLES = 2 * MAX_DEG + 30;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int MAX_PRINTS    = 20;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [DEG_W-1:0] cfg_wdata;
  logic      in_push;
  logic      in_full;
  in_word_t  in_word;
  logic      out_empty;
  logic      out_pop;
  out_word_t out_word;

  // Predictor state
  logic [DEG_W-1:0] cur_degree;
  s64_t      acc_sum;
  bit        acc_clip;
  bit        term_clip;
  out_word_t divergence_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int err_count;
  int cycle_count;

  polynomial_bregman_divergence_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturating arithmetic; every clip marks the current pair
  function automatic s64_t clip_add(s64_t a, s64_t b);
    s65_t s;
    s = s65_t'(a) + s65_t'(b);
    if (s > s65_t'(S64_MAX)) begin
      term_clip = 1'b1;
      return S64_MAX;
    end
    if (s < s65_t'(S64_MIN)) begin
      term_clip = 1'b1;
      return S64_MIN;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic s64_t clip_neg(s64_t a);
    if (a == S64_MIN) begin
      term_clip = 1'b1;
      return S64_MAX;
    end
    return -a;
  endfunction

  function automatic s64_t clip_mul(s64_t a, s64_t b);
    s128_t pa;
    s128_t pb;
    s128_t p;
    pa = a;
    pb = b;
    p = pa * pb;
    if (p > s128_t'(S64_MAX)) begin
      term_clip = 1'b1;
      return S64_MAX;
    end
    if (p < s128_t'(S64_MIN)) begin
      term_clip = 1'b1;
      return S64_MIN;
    end
    return p[ACC_W-1:0];
  endfunction

  function automatic s64_t clip_pow(s64_t base, int e);
    s64_t r;
    r = S64_ONE;
    for (int i = 0; i < e; i++) r = clip_mul(r, base);
    return r;
  endfunction

  // Fold one accepted pair into the running divergence; queue the sum on last
  function automatic void fold_pair(in_word_t w);
    int   d;
    s64_t u;
    s64_t v;
    s64_t pu;
    s64_t pv;
    s64_t lin;
    s64_t term;
    out_word_t r;
    d = cur_degree;
    if (d < 1) d = 1;
    if (d > MAX_DEG) d = MAX_DEG;
    u = w.u_value;
    v = w.v_value;
    term_clip = 1'b0;
    pu = clip_pow(u, d);
    pv = clip_pow(v, d);
    lin = clip_mul(s64_t'(d), u - v);
    lin = clip_mul(lin, clip_pow(v, d - 1));
    term = clip_add(pu, clip_neg(pv));
    // odd degree with a non-positive v flips the sign of the linear term
    if ((d % 2 == 1) && (v <= 0)) term = clip_add(term, lin);
    else term = clip_add(term, clip_neg(lin));
    acc_sum = clip_add(acc_sum, term);
    if (term_clip) acc_clip = 1'b1;
    if (w.last) begin
      r.divergence = acc_sum;
      r.saturated  = acc_clip;
      divergence_q.push_back(r);
      acc_sum  = '0;
      acc_clip = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_pair(input sample_t u, input sample_t v, input bit last);
    in_word_t w;
    w.u_value = u;
    w.v_value = v;
    w.last    = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
    fold_pair(w);
    @(negedge clk);
  endtask

  // Drop push, wait for every expected word, then let words with no result finish
  task automatic wait_idle();
    in_push <= 1'b0;
    while (divergence_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_degree(input logic [DEG_W-1:0] deg);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= deg;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_degree = deg;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return sample_t'(127);
      1: return sample_t'(-128);
      2: return sample_t'(0);
      default: return sample_t'($urandom_range(255));
    endcase
  endfunction

  // Extremes, every degree, sign cases and the degree clamp
  task automatic test_directed();
    send_idle_pct = 19;
    recv_idle_pct = 57;
    // reset degree is 2: squared distance
    send_pair(3, 1, 1'b1);
    send_pair(127, -128, 1'b1);
    send_pair(-128, 127, 1'b1);
    send_pair(-128, -128, 1'b0);
    send_pair(0, 0, 1'b1);
    write_degree(1);
    send_pair(5, -3, 1'b1);
    // degree 0 runs as degree 1
    write_degree(0);
    send_pair(-7, 9, 1'b1);
    write_degree(3);
    send_pair(4, 0, 1'b0);
    send_pair(4, -2, 1'b0);
    send_pair(-4, 2, 1'b1);
    write_degree(7);
    send_pair(127, -128, 1'b1);
    send_pair(-128, 127, 1'b1);
    send_pair(-128, 0, 1'b1);
    send_pair(1, -1, 1'b0);
    send_pair(-1, 1, 1'b1);
    write_degree(4);
    send_pair(-128, 127, 1'b1);
    write_degree(5);
    send_pair(127, -128, 1'b1);
    write_degree(6);
    send_pair(-128, -128, 1'b0);
    send_pair(127, 0, 1'b1);
    wait_idle();
  endtask

  // Long vector that drives the sum into positive saturation, then back off it
  task automatic test_accumulator_clip();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_degree(7);
    for (int i = 0; i < 1080; i++) send_pair(127, -128, 1'b0);
    for (int i = 0; i < 4; i++) send_pair(-128, 0, 1'b0);
    send_pair(3, 2, 1'b1);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps pushing
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_degree(2);
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_pair(pick_sample(), pick_sample(), (i % 2) == 1);
    wait_idle();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct);
    int len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_degree(DEG_W'($urandom_range(7)));
    for (int n = 0; n < 85; n += len) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) send_pair(pick_sample(), pick_sample(), i == len - 1);
      if ($urandom_range(11) == 0) write_degree(DEG_W'($urandom_range(7)));
    end
    wait_idle();
  endtask

  // Receiver: random pop, or a counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_pop <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each popped word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && !out_empty && out_pop) begin
      if (divergence_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word divergence=%0d saturated=%0b",
                                  out_word.divergence, out_word.saturated));
      end else begin
        exp_w = divergence_q.pop_front();
        if (out_word.divergence !== exp_w.divergence)
          report_mismatch($sformatf("divergence got %0d want %0d",
                                    out_word.divergence, exp_w.divergence));
        if (out_word.saturated !== exp_w.saturated)
          report_mismatch($sformatf("saturated got %0b want %0b",
                                    out_word.saturated, exp_w.saturated));
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_word       = '0;
    out_pop       = 1'b0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    err_count     = 0;
    cycle_count   = 0;
    cur_degree    = DEG_RESET;
    acc_sum       = '0;
    acc_clip      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_accumulator_clip();
    test_backpressure();
    test_random(19, 57);
    test_random(57, 19);
    test_random(0, 0);

    wait_idle();
    if (divergence_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", divergence_q.size()));
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
